FILE: rtl/core/two_class_pool_allocator_unit_macros.svh
// Assertion macros used by the pool allocator port checker.
`ifndef TWO_CLASS_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define TWO_CLASS_POOL_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TCPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TCPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tcpa_pkg.sv
// Types, sizes and codes of the two-class pool allocator.
package tcpa_pkg;

    localparam int SMALL_CHUNKS = 1024;
    localparam int LARGE_CHUNKS = 128;
    localparam int MAX_THREADS  = 8;
    localparam int SMALL_LIMIT  = 64;

    localparam int NUM_POOLS = MAX_THREADS + 1;
    localparam int MAX_CHUNKS = (SMALL_CHUNKS > LARGE_CHUNKS) ? SMALL_CHUNKS : LARGE_CHUNKS;
    localparam int CNT_W     = $clog2(MAX_CHUNKS + 1);
    localparam int OWN_DEPTH = 2 * MAX_THREADS;
    localparam int OWN_W     = (OWN_DEPTH > 1) ? $clog2(OWN_DEPTH) : 1;
    localparam int SM_DEPTH  = NUM_POOLS * SMALL_CHUNKS;
    localparam int LG_DEPTH  = NUM_POOLS * LARGE_CHUNKS;
    localparam int SM_AW     = $clog2(SM_DEPTH);
    localparam int LG_AW     = $clog2(LG_DEPTH);

    // fixed field widths
    localparam int TID_W  = 3;
    localparam int SIZE_W = 16;
    localparam int POOL_W = 4;
    localparam int IDX_W  = 10;
    localparam int ACT_W  = 4;
    localparam int MODE_W = 2;
    localparam int LIM_W  = 5;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_THREADS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_MODE      = 2'd1;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [ACT_W-1:0]  ACTIVE_RESET = 4'd8;
    localparam logic [MODE_W-1:0] MODE_RESET   = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OOM      = 2'd1,
        STATUS_INACTIVE = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic              req_type;
        logic [TID_W-1:0]  thread_id;
        logic [SIZE_W-1:0] request_size;
        logic [POOL_W-1:0] free_pool;
        logic              free_class;
        logic [IDX_W-1:0]  free_index;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [POOL_W-1:0] alloc_pool;
        logic              alloc_class;
        logic [IDX_W-1:0]  alloc_index;
        logic              used_overflow;
    } rsp_t;

    typedef struct packed {
        logic exec;
        logic load;
        logic cfg_we;
    } dp_cmd_t;

    function automatic logic [CNT_W-1:0] class_size(input logic cls);
        return cls ? CNT_W'(LARGE_CHUNKS) : CNT_W'(SMALL_CHUNKS);
    endfunction

endpackage

FILE: rtl/core/tcpa_ctrl.sv
// Handshake controller of the pool allocator: issue and result-load sequencing.
module tcpa_ctrl
    import tcpa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    output logic    rsp_valid,
    input  logic    rsp_ready,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        cmd.exec   = 1'b0;
        cmd.load   = 1'b0;
        cmd.cfg_we = cfg_valid && cfg_ready;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.exec  = req_valid;
            end
            ST_LOAD:
            begin
                cmd.load = slot_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // hold the result beat until taken
    always_comb
    begin
        if (cmd.load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

FILE: rtl/core/tcpa_datapath.sv
// Datapath of the pool allocator: free counts, free-stack memories, result register.
module tcpa_datapath
    import tcpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    input  req_t                  req,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output rsp_t                  rsp
);

    logic [ACT_W-1:0]  active_threads_reg;
    logic [MODE_W-1:0] pool_mode_reg;

    // free counts and low-water marks; a stack slot below the mark was never written and
    // reads back as its initial index, taken from the count rather than from the memory
    logic [CNT_W-1:0] own_cnt_reg [OWN_DEPTH];
    logic [CNT_W-1:0] own_low_reg [OWN_DEPTH];
    logic [CNT_W-1:0] ovf_cnt_reg [2];
    logic [CNT_W-1:0] ovf_low_reg [2];

    logic [IDX_W-1:0] small_mem [SM_DEPTH];
    logic [IDX_W-1:0] large_mem [LG_DEPTH];
    logic [IDX_W-1:0] sm_rd_reg;
    logic [IDX_W-1:0] lg_rd_reg;

    status_t           st_status_reg;
    logic [POOL_W-1:0] st_pool_reg;
    logic              st_cls_reg;
    logic [IDX_W-1:0]  st_idx_reg;
    logic              st_mem_reg;
    logic              st_ovf_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    logic [LIM_W-1:0]  at_ext;
    logic [LIM_W-1:0]  lim;
    logic              active;
    logic              own_usable;
    logic              is_free;
    logic              size_cls;
    logic              op_cls;
    logic [OWN_W-1:0]  sel;
    logic [CNT_W-1:0]  own_c;
    logic              use_own;
    logic [CNT_W-1:0]  c;
    logic [CNT_W-1:0]  lw;
    logic [CNT_W-1:0]  csize;
    logic              do_pop;
    logic              do_push;
    logic              from_init;
    logic [CNT_W-1:0]  pos;
    logic [POOL_W-1:0] pool_num;
    logic [SM_AW-1:0]  sm_addr;
    logic [LG_AW-1:0]  lg_addr;
    logic              sm_we;
    logic              sm_re;
    logic              lg_we;
    logic              lg_re;
    logic [CNT_W-1:0]  cnt_new;
    logic [CNT_W-1:0]  low_new;
    status_t           status_new;

    assign at_ext     = LIM_W'(active_threads_reg);
    assign lim        = (at_ext > LIM_W'(MAX_THREADS)) ? LIM_W'(MAX_THREADS) : at_ext;
    assign active     = LIM_W'(req.thread_id) < lim;
    assign own_usable = pool_mode_reg[1];
    assign is_free    = (req.req_type == REQ_FREE);
    assign size_cls   = req.request_size > SIZE_W'(SMALL_LIMIT);
    assign op_cls     = is_free ? req.free_class : size_cls;
    assign sel        = OWN_W'({req.thread_id, op_cls});
    assign own_c      = own_cnt_reg[sel];

    assign use_own = own_usable &&
        (is_free ? (req.free_pool == POOL_W'(req.thread_id)) : (own_c != '0));

    assign c     = use_own ? own_c : ovf_cnt_reg[op_cls];
    assign lw    = use_own ? own_low_reg[sel] : ovf_low_reg[op_cls];
    assign csize = class_size(op_cls);

    assign do_pop    = active && !is_free && (c != '0);
    assign do_push   = active && is_free && (c < csize);
    assign from_init = (c == lw);
    assign pos       = do_pop ? (c - CNT_W'(1)) : c;
    assign pool_num  = use_own ? POOL_W'(req.thread_id) : POOL_W'(MAX_THREADS);

    assign sm_addr = SM_AW'(pool_num) * SM_AW'(SMALL_CHUNKS) + SM_AW'(pos);
    assign lg_addr = LG_AW'(pool_num) * LG_AW'(LARGE_CHUNKS) + LG_AW'(pos);
    assign sm_we   = cmd.exec && do_push && !op_cls;
    assign lg_we   = cmd.exec && do_push && op_cls;
    assign sm_re   = cmd.exec && do_pop && !from_init && !op_cls;
    assign lg_re   = cmd.exec && do_pop && !from_init && op_cls;

    assign cnt_new = do_pop ? (c - CNT_W'(1)) : (c + CNT_W'(1));
    assign low_new = (do_pop && from_init) ? (c - CNT_W'(1)) : lw;

    always_comb
    begin
        if (!active)
        begin
            status_new = STATUS_INACTIVE;
        end
        else if (!is_free && (c == '0))
        begin
            status_new = STATUS_OOM;
        end
        else
        begin
            status_new = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_threads_reg <= ACTIVE_RESET;
            pool_mode_reg      <= MODE_RESET;
        end
        else if (cmd.cfg_we)
        begin
            case (cfg_index)
                CFG_ACTIVE_THREADS: active_threads_reg <= cfg_data[ACT_W-1:0];
                CFG_POOL_MODE:      pool_mode_reg      <= cfg_data[MODE_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < OWN_DEPTH; i++)
            begin
                own_cnt_reg[i] <= class_size(i[0]);
                own_low_reg[i] <= class_size(i[0]);
            end
            for (int j = 0; j < 2; j++)
            begin
                ovf_cnt_reg[j] <= class_size(j[0]);
                ovf_low_reg[j] <= class_size(j[0]);
            end
        end
        else if (cmd.exec && (do_pop || do_push))
        begin
            if (use_own)
            begin
                own_cnt_reg[sel] <= cnt_new;
                own_low_reg[sel] <= low_new;
            end
            else
            begin
                ovf_cnt_reg[op_cls] <= cnt_new;
                ovf_low_reg[op_cls] <= low_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
        begin
            small_mem[sm_addr] <= req.free_index;
        end
        if (sm_re)
        begin
            sm_rd_reg <= small_mem[sm_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lg_we)
        begin
            large_mem[lg_addr] <= req.free_index;
        end
        if (lg_re)
        begin
            lg_rd_reg <= large_mem[lg_addr];
        end
    end

    // capture the decision; the stack read is registered alongside it
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            st_status_reg <= status_new;
            st_pool_reg   <= do_pop ? pool_num : '0;
            st_cls_reg    <= (active && !is_free) ? op_cls : 1'b0;
            st_idx_reg    <= (do_pop && from_init) ? IDX_W'(csize - c) : '0;
            st_mem_reg    <= do_pop && !from_init;
            st_ovf_reg    <= active && !use_own;
        end
    end

    always_comb
    begin
        rsp_next.status        = st_status_reg;
        rsp_next.alloc_pool    = st_pool_reg;
        rsp_next.alloc_class   = st_cls_reg;
        rsp_next.alloc_index   = st_mem_reg ? (st_cls_reg ? lg_rd_reg : sm_rd_reg) : st_idx_reg;
        rsp_next.used_overflow = st_ovf_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

FILE: rtl/core/two_class_pool_allocator_unit.sv
// An accepted request is captured in the decision and stack-read registers, then
// loaded into the result register that drives the beat valid. No new request is
// taken until that load; the load state loads the registered free-stack read, and
// a stalled result holds that load and blocks the next request.
// Reset: every free count is full and each stack reads back in its initial order
// through per-stack low-water marks; no clearing pass, requests are taken at once.
// Top level of the two-class pool allocator.
module two_class_pool_allocator_unit
    import tcpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t cmd;

    tcpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    tcpa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp       (rsp)
    );

endmodule

FILE: rtl/core/tcpa_checker.sv
// Port-level checker of the pool allocator and its bind to the top level.
`include "two_class_pool_allocator_unit_macros.svh"

module tcpa_port_checks
    import tcpa_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // one request in flight at a time
    `TCPA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready,
        "request accepted while busy")

    // an accepted request with an empty result slot is answered from the load state without a stall
    `TCPA_ASSERT_NOW(a_result_due, clk, rst_n, req_valid && req_ready && !rsp_valid,
        ##2 rsp_valid, "result beat missing")

    `TCPA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp), "result beat dropped or changed")

    `TCPA_ASSERT_NOW(a_inactive_zero, clk, rst_n,
        rsp_valid && (rsp.status == STATUS_INACTIVE),
        (rsp.alloc_pool == 4'd0) && (rsp.alloc_index == 10'd0) && !rsp.used_overflow,
        "inactive thread result not clear")

endmodule

bind two_class_pool_allocator_unit tcpa_port_checks u_port_checks (.*);

FILE: test/tcpa_checker.sv
// Checker for the two-class pool allocator: tracks free stacks, predicts and compares grants.
`timescale 1ns / 100ps
module tcpa_checker
    import tcpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  req_t                  req,
    input  logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  rsp_t                  rsp,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned           fail_count,
    output int unsigned           pending
);

    logic [IDX_W-1:0]  small_stack [SM_DEPTH];
    logic [IDX_W-1:0]  large_stack [LG_DEPTH];
    int unsigned       free_cnt    [2*NUM_POOLS];
    logic [ACT_W-1:0]  active_reg;
    logic [MODE_W-1:0] mode_reg;
    rsp_t              grant_q[$];

    task automatic report(input string msg);
        $display("%0t ns: grant check: %s", $time, msg);
        fail_count++;
    endtask

    task automatic refill_pools();
        for (int p = 0; p < NUM_POOLS; p++)
        begin
            for (int k = 0; k < SMALL_CHUNKS; k++)
                small_stack[p*SMALL_CHUNKS + k] = IDX_W'(SMALL_CHUNKS - 1 - k);
            for (int k = 0; k < LARGE_CHUNKS; k++)
                large_stack[p*LARGE_CHUNKS + k] = IDX_W'(LARGE_CHUNKS - 1 - k);
            free_cnt[2*p]     = SMALL_CHUNKS;
            free_cnt[2*p + 1] = LARGE_CHUNKS;
        end
    endtask

    function automatic bit take_chunk(input int pool, input logic cls,
                                      output logic [IDX_W-1:0] idx);
        int c;
        c   = 2*pool + cls;
        idx = '0;
        if (free_cnt[c] == 0)
            return 1'b0;
        free_cnt[c]--;
        if (cls)
            idx = large_stack[pool*LARGE_CHUNKS + free_cnt[c]];
        else
            idx = small_stack[pool*SMALL_CHUNKS + free_cnt[c]];
        return 1'b1;
    endfunction

    function automatic void give_chunk(input int pool, input logic cls,
                                       input logic [IDX_W-1:0] idx);
        int c;
        int cap;
        c   = 2*pool + cls;
        cap = cls ? LARGE_CHUNKS : SMALL_CHUNKS;
        // drop a return onto a full stack
        if (free_cnt[c] >= cap)
            return;
        if (cls)
            large_stack[pool*LARGE_CHUNKS + free_cnt[c]] = idx;
        else
            small_stack[pool*SMALL_CHUNKS + free_cnt[c]] = idx;
        free_cnt[c]++;
    endfunction

    function automatic rsp_t predict_grant(input req_t r);
        rsp_t             o;
        int               lim;
        logic             cls;
        bit               got;
        logic [IDX_W-1:0] idx;
        o   = '0;
        lim = (active_reg > MAX_THREADS) ? MAX_THREADS : active_reg;
        if (r.thread_id >= lim)
            o.status = STATUS_INACTIVE;
        else if (r.req_type == REQ_ALLOC)
        begin
            cls           = (r.request_size <= SMALL_LIMIT) ? 1'b0 : 1'b1;
            o.alloc_class = cls;
            got           = 1'b0;
            // modes 2 and 3 use the thread's own pool first
            if (mode_reg[1])
                got = take_chunk(r.thread_id, cls, idx);
            if (got)
            begin
                o.alloc_pool  = POOL_W'(r.thread_id);
                o.alloc_index = idx;
            end
            else if (take_chunk(MAX_THREADS, cls, idx))
            begin
                o.alloc_pool    = POOL_W'(MAX_THREADS);
                o.alloc_index   = idx;
                o.used_overflow = 1'b1;
            end
            else
            begin
                o.status        = STATUS_OOM;
                o.used_overflow = 1'b1;
            end
        end
        else if (mode_reg[1] && r.free_pool == r.thread_id)
            give_chunk(r.thread_id, r.free_class, r.free_index);
        else
        begin
            give_chunk(MAX_THREADS, r.free_class, r.free_index);
            o.used_overflow = 1'b1;
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        rsp_t want;
        if (!rst_n)
        begin
            refill_pools();
            active_reg = ACTIVE_RESET;
            mode_reg   = MODE_RESET;
            grant_q.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ACTIVE_THREADS)
                    active_reg = cfg_data[ACT_W-1:0];
                else if (cfg_index == CFG_POOL_MODE)
                    mode_reg = cfg_data[MODE_W-1:0];
            end
            if (req_valid && req_ready)
                grant_q.push_back(predict_grant(req));
            if (rsp_valid && rsp_ready)
            begin
                if (grant_q.size() == 0)
                    report("result beat with no request outstanding");
                else
                begin
                    want = grant_q.pop_front();
                    if (rsp.status !== want.status)
                        report($sformatf("status %0d, expected %0d", rsp.status, want.status));
                    if (rsp.alloc_pool !== want.alloc_pool)
                        report($sformatf("alloc_pool %0d, expected %0d",
                                         rsp.alloc_pool, want.alloc_pool));
                    if (rsp.alloc_class !== want.alloc_class)
                        report($sformatf("alloc_class %0d, expected %0d",
                                         rsp.alloc_class, want.alloc_class));
                    if (rsp.alloc_index !== want.alloc_index)
                        report($sformatf("alloc_index %0d, expected %0d",
                                         rsp.alloc_index, want.alloc_index));
                    if (rsp.used_overflow !== want.used_overflow)
                        report($sformatf("used_overflow %0d, expected %0d",
                                         rsp.used_overflow, want.used_overflow));
                end
            end
            pending <= grant_q.size();
        end
    end

endmodule

FILE: test/tb_top.sv
// Stimulus and verdict for the two-class pool allocator.
`timescale 1ns / 100ps
module tb_top;
    import tcpa_pkg::*;

    localparam logic [MODE_W-1:0]    MODE_SHARED     = 2'd0;
    localparam logic [MODE_W-1:0]    MODE_SHARED_ALT = 2'd1;
    localparam logic [MODE_W-1:0]    MODE_FULL       = 2'd2;
    localparam logic [MODE_W-1:0]    MODE_FULL_ALT   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED      = 2'd3;
    localparam logic [POOL_W-1:0]    OVF_POOL        = POOL_W'(MAX_THREADS);
    localparam logic [POOL_W-1:0]    BAD_POOL        = 4'd15;
    localparam int                   MAX_WAIT        = 15;

    typedef struct packed {
        logic [POOL_W-1:0] pool;
        logic              cls;
        logic [IDX_W-1:0]  idx;
    } handle_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    req_t                  req       = '0;
    logic                  rsp_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  req_ready;
    logic                  rsp_valid;
    logic                  cfg_ready;
    rsp_t                  rsp;
    int unsigned           fail_count;
    int unsigned           pending;

    bit                    quiet_req  = 1'b0;
    bit                    quiet_rsp  = 1'b0;
    int                    rsp_hold   = 0;
    logic [ACT_W-1:0]      cur_active = ACTIVE_RESET;
    handle_t               live_q[$];
    bit                    alloc_sent_q[$];
    bit                    was_alloc;

    two_class_pool_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tcpa_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver stalls: a random hold after each result beat, none in quiet stretches.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if ($urandom_range(0, 63) == 0)
                    quiet_rsp = !quiet_rsp;
                rsp_hold = quiet_rsp ? 0 : $urandom_range(0, MAX_WAIT);
            end
            else if (rsp_hold > 0)
                rsp_hold--;
            rsp_ready <= (rsp_hold == 0);
        end
    end

    // Collect granted handles so later frees return real chunks. Sampled mid-cycle, where
    // the handshake of the coming edge is already settled.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready && alloc_sent_q.size() > 0)
            begin
                was_alloc = alloc_sent_q.pop_front();
                if (was_alloc && rsp.status == STATUS_OK)
                    live_q.push_back({rsp.alloc_pool, rsp.alloc_class, rsp.alloc_index});
            end
            if (req_valid && req_ready)
                alloc_sent_q.push_back(req.req_type == REQ_ALLOC);
        end
    end

    function automatic int thread_limit();
        return (cur_active > MAX_THREADS) ? MAX_THREADS : cur_active;
    endfunction

    function automatic logic [TID_W-1:0] pick_thread();
        int lim;
        lim = thread_limit();
        if (lim == 0)
            return TID_W'($urandom_range(0, (1 << TID_W) - 1));
        return TID_W'($urandom_range(0, lim - 1));
    endfunction

    function automatic req_t mk_req(input logic rt, input logic [TID_W-1:0] tid,
                                    input logic [SIZE_W-1:0] size,
                                    input logic [POOL_W-1:0] fpool, input logic fcls,
                                    input logic [IDX_W-1:0] fidx);
        req_t r;
        r.req_type     = rt;
        r.thread_id    = tid;
        r.request_size = size;
        r.free_pool    = fpool;
        r.free_class   = fcls;
        r.free_index   = fidx;
        return r;
    endfunction

    function automatic req_t make_item(input int alloc_pct, input int large_pct);
        req_t        r;
        handle_t     h;
        int          pick;
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        r     = noise[$bits(req_t)-1:0];
        // a share of fully random beats: foreign pools, bad pool numbers, idle threads
        if ($urandom_range(0, 99) < 15)
            return r;
        if ($urandom_range(0, 99) < alloc_pct || live_q.size() == 0)
        begin
            r.req_type  = REQ_ALLOC;
            r.thread_id = pick_thread();
            if ($urandom_range(0, 99) < large_pct)
                r.request_size = ($urandom_range(0, 7) == 0) ? {SIZE_W{1'b1}}
                               : SIZE_W'($urandom_range(SMALL_LIMIT + 1, (1 << SIZE_W) - 1));
            else
                r.request_size = ($urandom_range(0, 3) == 0) ? SIZE_W'(SMALL_LIMIT)
                               : SIZE_W'($urandom_range(0, SMALL_LIMIT));
        end
        else
        begin
            pick = $urandom_range(0, live_q.size() - 1);
            h    = live_q[pick];
            live_q.delete(pick);
            r.req_type = REQ_FREE;
            if (h.pool < thread_limit() && $urandom_range(0, 4) != 0)
                r.thread_id = h.pool[TID_W-1:0];
            else
                r.thread_id = pick_thread();
            r.free_pool  = h.pool;
            r.free_class = h.cls;
            r.free_index = h.idx;
        end
        return r;
    endfunction

    task automatic send_req(input req_t r);
        int gap;
        if ($urandom_range(0, 63) == 0)
            quiet_req = !quiet_req;
        gap = quiet_req ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
    endtask

    // Hold off until every result is back, then let the pipeline settle.
    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (index == CFG_ACTIVE_THREADS)
            cur_active = value[ACT_W-1:0];
    endtask

    task automatic run_phase(input logic [ACT_W-1:0] act, input logic [CFG_DATA_W-1:0] mode_word,
                             input int count, input int alloc_pct, input int large_pct);
        wait_idle();
        write_reg(CFG_ACTIVE_THREADS, act);
        write_reg(CFG_POOL_MODE, mode_word);
        repeat (count)
        begin
            if ($urandom_range(0, 199) == 0)
                wait_idle();
            send_req(make_item(alloc_pct, large_pct));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: eight threads, full pools
        send_req(mk_req(REQ_ALLOC, 3'd0, 16'd0, '0, 1'b0, '0));
        send_req(mk_req(REQ_ALLOC, 3'd0, SIZE_W'(SMALL_LIMIT), '0, 1'b0, '0));
        send_req(mk_req(REQ_ALLOC, 3'd0, SIZE_W'(SMALL_LIMIT + 1), '0, 1'b0, '0));
        send_req(mk_req(REQ_ALLOC, 3'd7, {SIZE_W{1'b1}}, '0, 1'b0, '0));
        send_req(mk_req(REQ_ALLOC, 3'd3, 16'd1, '0, 1'b0, '0));
        send_req(mk_req(REQ_FREE, 3'd0, '0, 4'd0, 1'b0, 10'd0));
        send_req(mk_req(REQ_FREE, 3'd0, '0, 4'd0, 1'b0, 10'd0));
        // own small stack is full again: this return is dropped
        send_req(mk_req(REQ_FREE, 3'd0, '0, 4'd0, 1'b0, {IDX_W{1'b1}}));
        // index far past the large class size, onto a full overflow stack
        send_req(mk_req(REQ_FREE, 3'd2, '0, OVF_POOL, 1'b1, {IDX_W{1'b1}}));
        send_req(mk_req(REQ_FREE, 3'd1, '0, 4'd5, 1'b0, 10'd7));
        send_req(mk_req(REQ_FREE, 3'd4, {SIZE_W{1'b1}}, BAD_POOL, 1'b1, 10'd512));
        send_req(mk_req(REQ_ALLOC, 3'd0, 16'd0, '0, 1'b0, '0));

        wait_idle();
        write_reg(CFG_ACTIVE_THREADS, 4'd3);
        send_req(mk_req(REQ_ALLOC, 3'd5, 16'd8, '0, 1'b0, '0));
        send_req(mk_req(REQ_FREE, 3'd7, '0, 4'd7, 1'b1, 10'd1));

        // shared-only mode: the own pool is bypassed both ways
        wait_idle();
        write_reg(CFG_POOL_MODE, CFG_DATA_W'(MODE_SHARED));
        send_req(mk_req(REQ_ALLOC, 3'd1, 16'd100, '0, 1'b0, '0));
        send_req(mk_req(REQ_FREE, 3'd1, '0, OVF_POOL, 1'b1, 10'd0));
        send_req(mk_req(REQ_FREE, 3'd1, '0, 4'd1, 1'b0, 10'd3));

        wait_idle();
        write_reg(CFG_ACTIVE_THREADS, 4'd0);
        send_req(mk_req(REQ_ALLOC, 3'd0, 16'd0, '0, 1'b0, '0));

        // out-of-range thread count and mode 3
        wait_idle();
        write_reg(CFG_ACTIVE_THREADS, 4'd15);
        write_reg(CFG_POOL_MODE, CFG_DATA_W'(MODE_FULL_ALT));
        send_req(mk_req(REQ_ALLOC, 3'd7, SIZE_W'(SMALL_LIMIT), '0, 1'b0, '0));
        send_req(mk_req(REQ_FREE, 3'd7, '0, 4'd7, 1'b0, 10'd0));

        run_phase(4'd3, CFG_DATA_W'(MODE_FULL), 250, 60, 50);
        // one thread, overflow only, mostly large: drains the overflow large class
        run_phase(4'd1, CFG_DATA_W'(MODE_SHARED), 300, 85, 85);
        run_phase(4'd15, CFG_DATA_W'(MODE_FULL_ALT), 250, 50, 40);
        // upper data bits set on the mode write
        run_phase(4'd0, {2'b11, MODE_SHARED_ALT}, 40, 50, 50);
        wait_idle();
        write_reg(CFG_UNUSED, 4'b1010);
        // two threads pulling large chunks until their own pools run dry
        run_phase(4'd2, CFG_DATA_W'(MODE_FULL), 350, 90, 95);
        run_phase(4'd9, CFG_DATA_W'(MODE_FULL), 300, 20, 50);
        run_phase(4'd5, CFG_DATA_W'(MODE_SHARED_ALT), 200, 60, 50);

        wait_idle();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
